FILE: rtl/core/icz_pkg.sv
// Shared types, constants and helpers for the zero-padded image convolution block.
// Every file of the block but icz_ram uses this package by scoped names.
// Depends on nothing.
package icz_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_RADIUS = 2;
    localparam int COEF_BITS  = 12;
    localparam int COEF_PITCH = 12;
    localparam int COEF_FRAC  = COEF_BITS - 3;

    localparam int PIX_W      = 8;
    localparam int WIN_SIDE   = 2 * MAX_RADIUS + 1;
    localparam int LINES      = 2 * MAX_RADIUS;
    localparam int LINE_WORD_W = PIX_W * LINES;
    localparam int NUM_ROWS   = 5;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int RAD_W      = 2;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 13;
    localparam int EFF_W_W    = $clog2(MAX_WIDTH + 1);
    localparam int TOTAL_W    = EFF_W_W + HEIGHT_W;
    localparam int POS_W      = TOTAL_W + 1;
    localparam int LAG_W      = EFF_W_W + 2;
    localparam int CFG_DATA_W = 60;
    localparam int CFG_IDX_W  = 3;
    localparam int PROD_W     = PIX_W + 1 + COEF_BITS;
    localparam int ROWSUM_W   = PROD_W + 3;
    localparam int SUM_W      = PROD_W + 5;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_A = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_C = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_D = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_E = 3'd7;

    typedef logic [NUM_ROWS-1:0][CFG_DATA_W-1:0] coef_rows_t;

    typedef struct packed {
        logic             op;
        logic [PIX_W-1:0] pixel_in;
    } in_beat_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             frame_end;
    } out_beat_t;

    // Sanitized configuration as seen by the datapath.
    typedef struct packed {
        logic                rad2;
        logic [EFF_W_W-1:0]  width;
        logic [HEIGHT_W-1:0] height;
        logic [TOTAL_W-1:0]  total;
        logic [LAG_W-1:0]    lag;
        coef_rows_t          coef;
    } cfg_t;

    // One classified beat travelling from the front to the back.
    typedef struct packed {
        logic [PIX_W-1:0]    pix;
        logic                emit;
        logic                last;
        logic [COL_W-1:0]    col;
        logic [WIN_SIDE-1:0] row_ok;
        logic [WIN_SIDE-1:0] col_ok;
    } work_t;

    function automatic logic signed [COEF_BITS-1:0] coef_at(
        input coef_rows_t rows, input int row, input int col);
        coef_at = rows[row][COEF_PITCH*col +: COEF_BITS];
    endfunction

endpackage

FILE: rtl/core/icz_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module icz_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/icz_front.sv
// Front end: accepts input beats, tracks input and output raster positions and
// classifies each beat (stored pixel, output due, border masks). Uses icz_pkg.
module icz_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  icz_pkg::cfg_t    cfg,
    input  logic             s_valid,
    output logic             s_ready,
    input  icz_pkg::in_beat_t s_data,
    input  logic             q_full,
    output logic             q_push,
    output icz_pkg::work_t   q_data
);

    logic [icz_pkg::POS_W-1:0]    in_pos_reg, in_pos_next;
    logic [icz_pkg::COL_W-1:0]    in_col_reg, in_col_next;
    logic [icz_pkg::LAG_W-1:0]    diff_reg, diff_next;
    logic [icz_pkg::TOTAL_W-1:0]  out_pos_reg, out_pos_next;
    logic [icz_pkg::HEIGHT_W-1:0] out_row_reg, out_row_next;
    logic [icz_pkg::COL_W-1:0]    out_col_reg, out_col_next;

    logic                         accept;
    logic                         emit;
    logic                         last;
    logic [icz_pkg::COL_W-1:0]    w_last;
    logic [icz_pkg::PIX_W-1:0]    pix;
    logic [icz_pkg::WIN_SIDE-1:0] row_ok;
    logic [icz_pkg::WIN_SIDE-1:0] col_ok;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign q_push  = accept;
    assign w_last  = icz_pkg::COL_W'(cfg.width - 1'b1);

    always_comb begin
        int rv;
        int rr;
        int cc;
        rv = cfg.rad2 ? 2 : 1;
        pix = (!s_data.op && (in_pos_reg < icz_pkg::POS_W'(cfg.total)))
            ? s_data.pixel_in : '0;
        emit = (diff_reg >= cfg.lag);
        last = emit && ((icz_pkg::POS_W'(out_pos_reg) + 1'b1) >= icz_pkg::POS_W'(cfg.total));
        // Window line k holds rows r+R-k; column k holds columns c+R-k.
        for (int k = 0; k < icz_pkg::WIN_SIDE; k++) begin
            rr = int'(out_row_reg) + rv - k;
            cc = int'(out_col_reg) + rv - k;
            row_ok[k] = (k <= 2 * rv) && (rr >= 0) && (rr < int'(cfg.height));
            col_ok[k] = (k <= 2 * rv) && (cc >= 0) && (cc < int'(cfg.width));
        end
    end

    always_comb begin
        in_pos_next  = in_pos_reg;
        in_col_next  = in_col_reg;
        diff_next    = diff_reg;
        out_pos_next = out_pos_reg;
        out_row_next = out_row_reg;
        out_col_next = out_col_reg;
        if (accept) begin
            if (last) begin
                in_pos_next  = '0;
                in_col_next  = '0;
                diff_next    = '0;
                out_pos_next = '0;
                out_row_next = '0;
                out_col_next = '0;
            end else begin
                in_pos_next = in_pos_reg + 1'b1;
                in_col_next = (in_col_reg == w_last) ? '0 : in_col_reg + 1'b1;
                if (emit) begin
                    out_pos_next = out_pos_reg + 1'b1;
                    if (out_col_reg == w_last) begin
                        out_col_next = '0;
                        out_row_next = out_row_reg + 1'b1;
                    end else begin
                        out_col_next = out_col_reg + 1'b1;
                    end
                end else begin
                    diff_next = diff_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_pos_reg  <= '0;
            in_col_reg  <= '0;
            diff_reg    <= '0;
            out_pos_reg <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
        end else begin
            in_pos_reg  <= in_pos_next;
            in_col_reg  <= in_col_next;
            diff_reg    <= diff_next;
            out_pos_reg <= out_pos_next;
            out_row_reg <= out_row_next;
            out_col_reg <= out_col_next;
        end
    end

    always_comb begin
        q_data.pix    = pix;
        q_data.emit   = emit;
        q_data.last   = last;
        q_data.col    = in_col_reg;
        q_data.row_ok = row_ok;
        q_data.col_ok = col_ok;
    end

endmodule

FILE: rtl/core/icz_queue.sv
// Short register queue between the front end and the back end.
// Uses icz_pkg for the work item type and depth.
module icz_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  icz_pkg::work_t push_data,
    output logic           full,
    input  logic           pop,
    output icz_pkg::work_t pop_data,
    output logic           empty
);

    icz_pkg::work_t               mem_reg [icz_pkg::QUEUE_DEPTH];
    logic [icz_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [icz_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [icz_pkg::QCNT_W-1:0]   count_reg, count_next;

    assign full     = (count_reg == icz_pkg::QCNT_W'(icz_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/core/icz_back.sv
// Back end: line store, window shift registers, multiplier lanes, adder tree,
// rounding and saturation, and the output register. Uses icz_pkg and icz_ram.
module icz_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  icz_pkg::cfg_t        cfg,
    input  logic                 q_empty,
    output logic                 q_pop,
    input  icz_pkg::work_t       q_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output icz_pkg::out_beat_t   m_data
);

    logic                         en;
    logic [icz_pkg::LINE_WORD_W-1:0] rdata;
    logic [icz_pkg::LINE_WORD_W-1:0] line_word;
    logic [icz_pkg::LINE_WORD_W-1:0] wr_word;
    logic [icz_pkg::PIX_W-1:0]    col_vec [icz_pkg::WIN_SIDE];

    logic                         s1_valid_reg;
    icz_pkg::work_t               s1_item_reg;
    logic                         fwd_reg;
    logic [icz_pkg::LINE_WORD_W-1:0] fwd_word_reg;

    logic [icz_pkg::PIX_W-1:0]    win_reg [icz_pkg::WIN_SIDE][icz_pkg::WIN_SIDE];

    logic                         s2_valid_reg;
    logic                         s2_last_reg;
    logic [icz_pkg::WIN_SIDE-1:0] s2_row_ok_reg;
    logic [icz_pkg::WIN_SIDE-1:0] s2_col_ok_reg;
    logic signed [icz_pkg::PROD_W-1:0] prod [icz_pkg::WIN_SIDE][icz_pkg::WIN_SIDE];

    logic                         s3_valid_reg;
    logic                         s3_last_reg;
    logic signed [icz_pkg::PROD_W-1:0] prod_reg [icz_pkg::WIN_SIDE][icz_pkg::WIN_SIDE];
    logic signed [icz_pkg::ROWSUM_W-1:0] row_sum [icz_pkg::WIN_SIDE];

    logic                         s4_valid_reg;
    logic                         s4_last_reg;
    logic signed [icz_pkg::ROWSUM_W-1:0] row_sum_reg [icz_pkg::WIN_SIDE];
    logic [icz_pkg::PIX_W-1:0]    result_pix;

    logic                         m_valid_reg;
    icz_pkg::out_beat_t           m_data_reg;

    // The whole back pipeline moves in lock step whenever the output can take a beat.
    assign en    = !m_valid_reg || m_ready;
    assign q_pop = en && !q_empty;

    icz_ram #(
        .WIDTH (icz_pkg::LINE_WORD_W),
        .DEPTH (icz_pkg::MAX_WIDTH)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (en && s1_valid_reg),
        .waddr (s1_item_reg.col),
        .wdata (wr_word),
        .re    (q_pop),
        .raddr (q_data.col),
        .rdata (rdata)
    );

    // With a one-pixel row the next beat reads the address written this cycle,
    // so the freshly written word is forwarded instead.
    assign line_word = fwd_reg ? fwd_word_reg : rdata;

    always_comb begin
        col_vec[0] = s1_item_reg.pix;
        for (int i = 1; i < icz_pkg::WIN_SIDE; i++) begin
            col_vec[i] = line_word[(i-1)*icz_pkg::PIX_W +: icz_pkg::PIX_W];
        end
        for (int i = 0; i < icz_pkg::LINES; i++) begin
            wr_word[i*icz_pkg::PIX_W +: icz_pkg::PIX_W] = col_vec[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            fwd_reg      <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= q_pop;
            fwd_reg      <= q_pop && s1_valid_reg && (q_data.col == s1_item_reg.col);
            s2_valid_reg <= s1_valid_reg && s1_item_reg.emit;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            m_valid_reg  <= s4_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < icz_pkg::WIN_SIDE; i++) begin
                for (int j = 0; j < icz_pkg::WIN_SIDE; j++) begin
                    win_reg[i][j] <= '0;
                end
            end
        end else if (en && s1_valid_reg) begin
            for (int i = 0; i < icz_pkg::WIN_SIDE; i++) begin
                win_reg[i][0] <= col_vec[i];
                for (int j = 1; j < icz_pkg::WIN_SIDE; j++) begin
                    win_reg[i][j] <= win_reg[i][j-1];
                end
            end
        end
    end

    always_comb begin
        logic [icz_pkg::PIX_W-1:0]          m;
        logic signed [icz_pkg::COEF_BITS-1:0] c;
        for (int i = 0; i < icz_pkg::WIN_SIDE; i++) begin
            for (int j = 0; j < icz_pkg::WIN_SIDE; j++) begin
                m = (s2_row_ok_reg[i] && s2_col_ok_reg[j]) ? win_reg[i][j] : '0;
                if (cfg.rad2) begin
                    c = icz_pkg::coef_at(cfg.coef, 2 * icz_pkg::MAX_RADIUS - i,
                                         2 * icz_pkg::MAX_RADIUS - j);
                end else if (i <= 2 && j <= 2) begin
                    c = icz_pkg::coef_at(cfg.coef, 2 - i, 2 - j);
                end else begin
                    c = '0;
                end
                prod[i][j] = $signed({1'b0, m}) * c;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < icz_pkg::WIN_SIDE; i++) begin
            row_sum[i] = '0;
            for (int j = 0; j < icz_pkg::WIN_SIDE; j++) begin
                row_sum[i] = row_sum[i] + icz_pkg::ROWSUM_W'(prod_reg[i][j]);
            end
        end
    end

    always_comb begin
        logic signed [icz_pkg::SUM_W-1:0] acc;
        logic [icz_pkg::SUM_W-1:0]        shifted;
        acc = icz_pkg::SUM_W'(1 << (icz_pkg::COEF_FRAC - 1));
        for (int i = 0; i < icz_pkg::WIN_SIDE; i++) begin
            acc = acc + icz_pkg::SUM_W'(row_sum_reg[i]);
        end
        shifted = icz_pkg::SUM_W'(acc >>> icz_pkg::COEF_FRAC);
        if (acc < 0) begin
            result_pix = '0;
        end else if (shifted > icz_pkg::SUM_W'(255)) begin
            result_pix = '1;
        end else begin
            result_pix = shifted[icz_pkg::PIX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_item_reg   <= q_data;
            fwd_word_reg  <= wr_word;
            s2_last_reg   <= s1_item_reg.last;
            s2_row_ok_reg <= s1_item_reg.row_ok;
            s2_col_ok_reg <= s1_item_reg.col_ok;
            s3_last_reg   <= s2_last_reg;
            prod_reg      <= prod;
            s4_last_reg   <= s3_last_reg;
            row_sum_reg   <= row_sum;
            if (s4_valid_reg) begin
                m_data_reg.pixel_out <= result_pix;
                m_data_reg.frame_end <= s4_last_reg;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: rtl/core/image_convolution_zero_pad_top.sv
// Top level of the zero-padded 2-D image convolution block: configuration
// registers, front end, queue and back end. Uses icz_pkg, icz_front, icz_queue, icz_back.
//
//  Channel  Ports                                  Beat
//  input    s_valid, s_ready, s_data               op, pixel_in
//  result   m_valid, m_ready, m_data               pixel_out, frame_end
//  config   cfg_wr_en, cfg_index, cfg_wdata        register write, no wait
//
// One beat is accepted per clock cycle while the queue is not full. The result for
// the beat that completes its window passes the queue, the line RAM read, the window
// registers, the multiply and adder pipeline and the output register. Reset is
// synchronous and active low and clears all control state. The back pipeline stalls
// only on m_ready; the four-entry queue lets the input side keep taking beats meanwhile.
module image_convolution_zero_pad_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  icz_pkg::in_beat_t                 s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output icz_pkg::out_beat_t                m_data,
    input  logic                              cfg_wr_en,
    input  logic [icz_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [icz_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    logic [icz_pkg::RAD_W-1:0]    radius_reg;
    logic [icz_pkg::WIDTH_W-1:0]  width_reg;
    logic [icz_pkg::HEIGHT_W-1:0] height_reg;
    icz_pkg::coef_rows_t          coef_reg;

    logic [icz_pkg::EFF_W_W-1:0]  w_eff;
    logic [icz_pkg::HEIGHT_W-1:0] h_eff;
    logic                         rad2;
    icz_pkg::cfg_t                cfg;

    logic                         q_push;
    icz_pkg::work_t               q_push_data;
    logic                         q_full;
    logic                         q_pop;
    icz_pkg::work_t               q_pop_data;
    logic                         q_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= icz_pkg::RAD_W'(1);
            width_reg  <= icz_pkg::WIDTH_W'(1024);
            height_reg <= icz_pkg::HEIGHT_W'(1024);
            coef_reg   <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                icz_pkg::REG_RADIUS: radius_reg <= cfg_wdata[icz_pkg::RAD_W-1:0];
                icz_pkg::REG_WIDTH:  width_reg  <= cfg_wdata[icz_pkg::WIDTH_W-1:0];
                icz_pkg::REG_HEIGHT: height_reg <= cfg_wdata[icz_pkg::HEIGHT_W-1:0];
                icz_pkg::REG_COEF_A: coef_reg[0] <= cfg_wdata;
                icz_pkg::REG_COEF_B: coef_reg[1] <= cfg_wdata;
                icz_pkg::REG_COEF_C: coef_reg[2] <= cfg_wdata;
                icz_pkg::REG_COEF_D: coef_reg[3] <= cfg_wdata;
                icz_pkg::REG_COEF_E: coef_reg[4] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Out-of-range settings are clamped to the nearest legal value.
    always_comb begin
        rad2 = (icz_pkg::MAX_RADIUS > 1) && (radius_reg >= icz_pkg::RAD_W'(2));
        if (width_reg == '0) begin
            w_eff = icz_pkg::EFF_W_W'(1);
        end else if (int'(width_reg) > icz_pkg::MAX_WIDTH) begin
            w_eff = icz_pkg::EFF_W_W'(icz_pkg::MAX_WIDTH);
        end else begin
            w_eff = icz_pkg::EFF_W_W'(width_reg);
        end
        h_eff = (height_reg == '0) ? icz_pkg::HEIGHT_W'(1) : height_reg;
    end

    always_comb begin
        cfg.rad2   = rad2;
        cfg.width  = w_eff;
        cfg.height = h_eff;
        cfg.total  = icz_pkg::TOTAL_W'(w_eff) * icz_pkg::TOTAL_W'(h_eff);
        cfg.lag    = rad2 ? ((icz_pkg::LAG_W'(w_eff) << 1) + icz_pkg::LAG_W'(2))
                          : (icz_pkg::LAG_W'(w_eff) + icz_pkg::LAG_W'(1));
        cfg.coef   = coef_reg;
    end

    icz_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_data  (q_push_data)
    );

    icz_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    icz_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .q_data  (q_pop_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

FILE: tb/icz_scoreboard.sv
// Checker for the zero-padded image convolution block: follows register writes,
// predicts each result from accepted input beats and compares result beats.
// Depends on icz_pkg.
module icz_scoreboard (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  icz_pkg::in_beat_t              s_data,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  icz_pkg::out_beat_t             m_data,
    input  logic                           cfg_wr_en,
    input  logic [icz_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [icz_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                             errors,
    output int                             pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING = 2 * icz_pkg::MAX_RADIUS * icz_pkg::MAX_WIDTH
                          + 2 * icz_pkg::MAX_RADIUS + 1;

    logic [icz_pkg::RAD_W-1:0]      radius_reg;
    logic [icz_pkg::WIDTH_W-1:0]    width_reg;
    logic [icz_pkg::HEIGHT_W-1:0]   height_reg;
    logic [icz_pkg::CFG_DATA_W-1:0] kernel_rows [icz_pkg::NUM_ROWS];
    logic [icz_pkg::PIX_W-1:0]      pix_ring [RING];
    int unsigned                    taken;
    int unsigned                    made;
    icz_pkg::out_beat_t             filtered_q [$];

    // Advances the frame by one beat; returns 1 when it yields a filtered pixel.
    function automatic bit filter_beat(input icz_pkg::in_beat_t b,
                                       output icz_pkg::out_beat_t res);
        int unsigned rad, w, h, total, lag, row, col;
        int          sum, rr, cc;
        logic signed [icz_pkg::COEF_BITS-1:0] k;
        logic [icz_pkg::PIX_W-1:0] v;
        rad = (radius_reg < 1) ? 1 : (radius_reg > icz_pkg::MAX_RADIUS)
            ? icz_pkg::MAX_RADIUS : radius_reg;
        w = (width_reg < 1) ? 1 : (width_reg > icz_pkg::MAX_WIDTH)
            ? icz_pkg::MAX_WIDTH : width_reg;
        h = (height_reg < 1) ? 1 : height_reg;
        total = w * h;
        lag = rad * w + rad;
        pix_ring[taken % RING] = (b.op == 1'b0 && taken < total) ? b.pixel_in : '0;
        taken++;
        if (taken <= made + lag) return 0;
        row = made / w;
        col = made % w;
        sum = 0;
        for (int dy = -int'(rad); dy <= int'(rad); dy++) begin
            for (int dx = -int'(rad); dx <= int'(rad); dx++) begin
                rr = int'(row) + dy;
                cc = int'(col) + dx;
                v = '0;
                if (rr >= 0 && rr < int'(h) && cc >= 0 && cc < int'(w))
                    v = pix_ring[(rr * w + cc) % RING];
                k = kernel_rows[dy + rad][icz_pkg::COEF_PITCH * (dx + rad) +: icz_pkg::COEF_BITS];
                sum += int'(v) * int'(k);
            end
        end
        sum += 1 << (icz_pkg::COEF_FRAC - 1);
        if (sum < 0) res.pixel_out = '0;
        else if ((sum >>> icz_pkg::COEF_FRAC) > 255) res.pixel_out = 8'd255;
        else res.pixel_out = icz_pkg::PIX_W'(sum >>> icz_pkg::COEF_FRAC);
        res.frame_end = (made + 1 >= total);
        if (res.frame_end) begin
            taken = 0;
            made = 0;
        end else begin
            made++;
        end
        return 1;
    endfunction

    always @(posedge aclk) begin
        icz_pkg::out_beat_t res, want;
        if (!aresetn) begin
            radius_reg <= 1;
            width_reg  <= 1024;
            height_reg <= 1024;
            for (int i = 0; i < icz_pkg::NUM_ROWS; i++) kernel_rows[i] <= '0;
            taken = 0;
            made = 0;
            errors = 0;
            filtered_q.delete();
            pending = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    icz_pkg::REG_RADIUS: radius_reg <= cfg_wdata[icz_pkg::RAD_W-1:0];
                    icz_pkg::REG_WIDTH:  width_reg  <= cfg_wdata[icz_pkg::WIDTH_W-1:0];
                    icz_pkg::REG_HEIGHT: height_reg <= cfg_wdata[icz_pkg::HEIGHT_W-1:0];
                    default: kernel_rows[cfg_index - icz_pkg::REG_COEF_A] <= cfg_wdata;
                endcase
            end
            if (s_valid && s_ready && filter_beat(s_data, res))
                filtered_q.insert(filtered_q.size(), res);
            if (m_valid && m_ready) begin
                if (filtered_q.size() == 0) begin
                    $error("unexpected result beat: pixel_out %0d frame_end %0d",
                           m_data.pixel_out, m_data.frame_end);
                    errors++;
                end else begin
                    want = filtered_q.pop_front();
                    if (m_data.pixel_out !== want.pixel_out) begin
                        $error("pixel_out: expected %0d, actual %0d",
                               want.pixel_out, m_data.pixel_out);
                        errors++;
                    end
                    if (m_data.frame_end !== want.frame_end) begin
                        $error("frame_end: expected %0d, actual %0d",
                               want.frame_end, m_data.frame_end);
                        errors++;
                    end
                end
            end
            pending = filtered_q.size();
        end
    end
endmodule

FILE: tb/image_convolution_zero_pad_top_tb.sv
// Top of the testbench for the zero-padded image convolution block: clock, reset,
// register writes, pixel stimulus and result back-pressure, plus the verdict.
// Depends on icz_pkg, image_convolution_zero_pad_top and icz_scoreboard.
module image_convolution_zero_pad_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KERN_SOBEL = 0;
    localparam int KERN_HALF  = 1;
    localparam int KERN_RAND  = 2;
    localparam int KERN_SOFT  = 3;
    localparam int KERN_BOX   = 4;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    icz_pkg::in_beat_t              s_data = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    icz_pkg::out_beat_t             m_data;
    logic                           cfg_wr_en = 1'b0;
    logic [icz_pkg::CFG_IDX_W-1:0]  cfg_index = icz_pkg::REG_RADIUS;
    logic [icz_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    int                             errors;
    int                             pending;
    int                             beats_sent = 0;
    bit                             no_gaps = 0;

    always #5 aclk = ~aclk;

    image_convolution_zero_pad_top dut (.*);

    icz_scoreboard scoreboard (.*);

    initial begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_beat(input logic op, input logic [icz_pkg::PIX_W-1:0] pix);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data.op <= op;
        s_data.pixel_in <= pix;
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
    endtask

    task automatic write_reg(input logic [icz_pkg::CFG_IDX_W-1:0] idx,
                             input logic [icz_pkg::CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    function automatic logic signed [icz_pkg::COEF_BITS-1:0] pick_coef(input int kind,
                                                                       input int i,
                                                                       input int j);
        int sobel [3] = '{-1, 0, 1};
        int mid   [3] = '{1, 2, 1};
        case (kind)
            KERN_SOBEL: return (i < 3 && j < 3)
                ? icz_pkg::COEF_BITS'(sobel[i] * mid[j] * 512) : '0;
            KERN_HALF:  return ((i == 2 && j == 2) || (i == 1 && j == 1))
                ? icz_pkg::COEF_BITS'(256) : '0;
            KERN_RAND:  return icz_pkg::COEF_BITS'($urandom);
            KERN_SOFT:  return icz_pkg::COEF_BITS'(int'($urandom_range(0, 160)) - 60);
            default:    return icz_pkg::COEF_BITS'(57);
        endcase
    endfunction

    // Waits for the pipeline to empty, then loads a complete register set.
    task automatic load_setup(input int rad, input int w, input int h, input int kind);
        logic [icz_pkg::CFG_DATA_W-1:0] row;
        s_valid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        write_reg(icz_pkg::REG_RADIUS, icz_pkg::CFG_DATA_W'(rad));
        write_reg(icz_pkg::REG_WIDTH, icz_pkg::CFG_DATA_W'(w));
        write_reg(icz_pkg::REG_HEIGHT, icz_pkg::CFG_DATA_W'(h));
        for (int i = 0; i < icz_pkg::NUM_ROWS; i++) begin
            for (int j = 0; j < 5; j++) begin
                row[icz_pkg::COEF_PITCH * j +: icz_pkg::COEF_BITS] = pick_coef(kind, i, j);
            end
            write_reg(icz_pkg::CFG_IDX_W'(icz_pkg::REG_COEF_A + i), row);
        end
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // One frame of pixels followed by enough pad beats to drain it. Some pad beats
    // land inside the frame and some pixels land in the drain, where they act as pads.
    task automatic run_frame(input int rad, input int w, input int h, input int kind,
                             input int inner_pad_pct, input int drain_pix_pct);
        int re, we, he, r;
        logic [icz_pkg::PIX_W-1:0] pix;
        load_setup(rad, w, h, kind);
        re = (rad < 1) ? 1 : (rad > icz_pkg::MAX_RADIUS) ? icz_pkg::MAX_RADIUS : rad;
        we = (w < 1) ? 1 : (w > icz_pkg::MAX_WIDTH) ? icz_pkg::MAX_WIDTH : w;
        he = (h < 1) ? 1 : h;
        for (int i = 0; i < we * he; i++) begin
            r = $urandom_range(0, 99);
            pix = (r < 12) ? 8'd0 : (r < 24) ? 8'd255 : icz_pkg::PIX_W'($urandom);
            send_beat($urandom_range(0, 99) < inner_pad_pct, pix);
        end
        for (int i = 0; i < re * we + re; i++)
            send_beat($urandom_range(0, 99) >= drain_pix_pct, icz_pkg::PIX_W'($urandom));
    endtask

    initial begin
        int run;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            m_ready <= 1'b1;
            run = $urandom_range(1, 30);
            repeat (run) @(posedge aclk);
            if (beats_sent > 450 && beats_sent < 700) begin
                // Long hold-off so the queue fills and the input side stalls.
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
            end else if (pick_gap() > 0) begin
                m_ready <= 1'b0;
                repeat (pick_gap() + 1) @(posedge aclk);
            end
        end
    end

    initial begin
        int lim;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // Directed frames: Sobel, half-weight rounding, pads inside, pixels in drain.
        run_frame(1, 4, 3, KERN_SOBEL, 10, 40);
        run_frame(2, 3, 2, KERN_HALF, 0, 50);
        // Register values out of range and extreme sizes.
        run_frame(0, 5, 2, KERN_SOFT, 5, 10);
        run_frame(3, 4, 3, KERN_BOX, 5, 10);
        run_frame(1, 0, 3, KERN_RAND, 5, 10);
        run_frame(2, 6, 0, KERN_SOFT, 5, 10);
        run_frame(1, 1, 1, KERN_HALF, 0, 0);
        run_frame(2, 1, 1, KERN_SOFT, 0, 0);
        no_gaps = 1;
        run_frame(2, 150, 3, KERN_SOBEL, 2, 10);
        no_gaps = 0;
        run_frame(1, 1, 40, KERN_HALF, 2, 10);
        while (beats_sent < 1500) begin
            no_gaps = ($urandom_range(0, 4) == 0);
            run_frame($urandom_range(0, 9) == 0 ? $urandom_range(0, 3) : $urandom_range(1, 2),
                      $urandom_range(1, 12), $urandom_range(1, 8), $urandom_range(0, 4),
                      $urandom_range(0, 10), $urandom_range(0, 30));
        end
        s_valid <= 1'b0;
        lim = 0;
        while (pending != 0 && lim < 100000) begin
            @(posedge aclk);
            lim++;
        end
        repeat (30) @(posedge aclk);
        if (errors == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
